// File: design/adaptive_readahead_sizer_defines.svh
// Assertion helpers for the read-ahead sizer.
`ifndef ADAPTIVE_READAHEAD_SIZER_DEFINES_SVH
`define ADAPTIVE_READAHEAD_SIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ARSZ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARSZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/arsz_pkg.sv
package arsz_pkg;

  localparam int BUF_W     = 25;
  localparam int DEPTH_W   = 8;
  localparam int DMR_W     = 31;
  localparam int WIN_W     = 41;
  localparam int CFG_W     = 41;
  localparam int CFG_IDX_W = 3;
  localparam int CMD_W     = 2;
  localparam int BYTES_W   = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cmd_t CMD_CONSUME = 2'd0;
  localparam cmd_t CMD_DISCARD = 2'd1;
  localparam cmd_t CMD_START   = 2'd2;

  localparam cfg_idx_t REG_BUFFER_SIZE = 3'd0;
  localparam cfg_idx_t REG_DEVICE_MAX  = 3'd1;
  localparam cfg_idx_t REG_RA_LIMIT    = 3'd2;
  localparam cfg_idx_t REG_ADJUST_EN   = 3'd3;
  localparam cfg_idx_t REG_WINDOW      = 3'd4;

  localparam logic [BUF_W-1:0]   RST_BUFFER_SIZE = 25'd8192;
  localparam logic [DMR_W-1:0]   RST_DEVICE_MAX  = 31'd131072;
  localparam logic [DEPTH_W-1:0] RST_RA_LIMIT    = 8'd0;
  localparam logic [WIN_W-1:0]   RST_WINDOW      = 41'd4194304;

  // Result item, first field in the high bits.
  typedef struct packed {
    logic [DEPTH_W-1:0] learned_read_ahead;
    logic               slow_start;
    logic [DEPTH_W-1:0] cur_read_ahead;
    logic [BUF_W-1:0]   cur_buffer_bytes;
  } arsz_result_t;

  // Largest power of two not above v, zero for zero.
  function automatic logic [BUF_W-1:0] pow2_floor(input logic [BUF_W-1:0] v);
    logic [BUF_W-1:0] p;
    p = '0;
    for (int i = 0; i < BUF_W; i++) begin
      if (v[i]) begin
        p    = '0;
        p[i] = 1'b1;
      end
    end
    return p;
  endfunction

endpackage

// File: design/adaptive_readahead_sizer.sv
// Read-ahead sizer: one result per request, in request order.
// Each request passes the input register, then the result register, before out_tvalid.
// Throughput: one request per cycle unless out_tready stalls the output; next state is combinational.
// rst_n is synchronous, active low: config registers return to defaults, windows,
// sizes and depths clear to zero, and both pipeline stages empty.
`include "adaptive_readahead_sizer_defines.svh"

module adaptive_readahead_sizer #(
  parameter int HISTORY_WIDTH    = 48,
  parameter int MIN_BUFFER_FLOOR = 8192
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [arsz_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [arsz_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] byte_count, [32] consumer_waited, rest zero
  input  logic [arsz_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] cmd
  input  logic [arsz_pkg::CMD_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [24:0] cur_buffer_bytes, [32:25] cur_read_ahead, [33] slow_start,
  // [41:34] learned_read_ahead, rest zero
  output logic [arsz_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import arsz_pkg::*;

  localparam int HW = HISTORY_WIDTH;
  localparam int CW = (HW > WIN_W) ? HW : WIN_W;

  function automatic logic [HW-1:0] sat_add(input logic [HW-1:0] a, input logic [HW-1:0] b);
    logic [HW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[HW] ? {HW{1'b1}} : s[HW-1:0];
  endfunction

  // waste below 25 percent: 4 * unused < total
  function automatic logic under_target(input logic [HW-1:0] u, input logic [HW-1:0] t);
    return {u, 2'b00} < {2'b00, t};
  endfunction

  // config registers
  logic [BUF_W-1:0]   bufsz_cfg_r;
  logic [DMR_W-1:0]   dev_max_r;
  logic [DEPTH_W-1:0] ra_limit_r;
  logic               adj_en_r;
  logic [WIN_W-1:0]   window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bufsz_cfg_r <= RST_BUFFER_SIZE;
      dev_max_r   <= RST_DEVICE_MAX;
      ra_limit_r  <= RST_RA_LIMIT;
      adj_en_r    <= 1'b0;
      window_r    <= RST_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BUFFER_SIZE: bufsz_cfg_r <= cfg_wdata[BUF_W-1:0];
        REG_DEVICE_MAX:  dev_max_r   <= cfg_wdata[DMR_W-1:0];
        REG_RA_LIMIT:    ra_limit_r  <= cfg_wdata[DEPTH_W-1:0];
        REG_ADJUST_EN:   adj_en_r    <= cfg_wdata[0];
        REG_WINDOW:      window_r    <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic               s1_valid_r;
  cmd_t               s1_cmd_r;
  logic [BYTES_W-1:0] s1_bytes_r;
  logic               s1_waited_r;
  logic               s1_adv;
  logic               out_valid_r;
  arsz_result_t       out_res_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r    <= in_tuser;
      s1_bytes_r  <= in_tdata[BYTES_W-1:0];
      s1_waited_r <= in_tdata[BYTES_W];
    end
  end

  // sizer state
  logic [HW-1:0]      cur_tot_r, cur_unu_r, prv_tot_r, prv_unu_r;
  logic [BUF_W-1:0]   buf_now_r;
  logic [DEPTH_W-1:0] depth_r, hist_r;
  logic               growing_r;

  logic [HW-1:0]      cur_tot_nxt, cur_unu_nxt, prv_tot_nxt, prv_unu_nxt;
  logic [BUF_W-1:0]   buf_now_nxt;
  logic [DEPTH_W-1:0] depth_nxt, hist_nxt;
  logic               growing_nxt;

  // capped and minimal sizes, from config only
  logic [DMR_W-1:0] dev_max;
  logic [BUF_W-1:0] capped, min_q, min_m, minsz;
  logic [BUF_W-1:0] floor_sz;

  assign floor_sz = BUF_W'(MIN_BUFFER_FLOOR);

  always_comb begin
    dev_max = (dev_max_r == '0) ? DMR_W'(1) : dev_max_r;
    // when the config exceeds the cap the cap is below 2^25
    capped  = ({{(DMR_W-BUF_W){1'b0}}, bufsz_cfg_r} <= dev_max) ? bufsz_cfg_r
                                                              : pow2_floor(dev_max[BUF_W-1:0]);
    min_q   = capped >> 2;
    min_m   = (min_q < floor_sz) ? floor_sz : min_q;
    minsz   = (min_m < capped) ? min_m : capped;
  end

  // history windows after recording this request
  logic          rec_en;
  logic [HW-1:0] add_unu, rec_tot, rec_unu;
  logic [HW-1:0] w_cur_tot, w_cur_unu, w_prv_tot, w_prv_unu;
  logic [HW-1:0] sum_tot, sum_unu;
  logic          roll;

  always_comb begin
    rec_en  = adj_en_r && ((s1_cmd_r == CMD_CONSUME) || (s1_cmd_r == CMD_DISCARD));
    add_unu = (s1_cmd_r == CMD_DISCARD) ? HW'(s1_bytes_r) : '0;
    rec_tot = sat_add(cur_tot_r, HW'(s1_bytes_r));
    rec_unu = sat_add(cur_unu_r, add_unu);
    roll    = CW'(rec_tot) >= CW'(window_r);
    if (!rec_en) begin
      w_cur_tot = cur_tot_r;
      w_cur_unu = cur_unu_r;
      w_prv_tot = prv_tot_r;
      w_prv_unu = prv_unu_r;
    end else if (roll) begin
      w_cur_tot = '0;
      w_cur_unu = '0;
      w_prv_tot = rec_tot;
      w_prv_unu = rec_unu;
    end else begin
      w_cur_tot = rec_tot;
      w_cur_unu = rec_unu;
      w_prv_tot = prv_tot_r;
      w_prv_unu = prv_unu_r;
    end
    sum_tot = sat_add(w_cur_tot, w_prv_tot);
    sum_unu = sat_add(w_cur_unu, w_prv_unu);
  end

  // slow-start growth on consume
  logic [BUF_W:0] dbl, grow_sz;
  logic [HW-1:0]  g_tot, g_unu;
  logic           grow_ok;

  always_comb begin
    dbl     = {buf_now_r, 1'b0};
    grow_sz = (dbl > {1'b0, capped}) ? {1'b0, capped} : dbl;
    g_tot   = sat_add(sum_tot, HW'(grow_sz));
    g_unu   = sat_add(sum_unu, HW'(grow_sz));
    grow_ok = under_target(g_unu, g_tot);
  end

  // shrink: largest power of two not above (total - 4*unused)/3, found by
  // comparing the difference against 3 << k instead of dividing
  logic              ut;
  logic [HW+1:0]     diff_w;
  logic [HW-1:0]     diff;
  logic [BUF_W:0]    ge;
  logic [BUF_W-1:0]  p2, shr_sz, base_buf;
  logic              shrink;

  always_comb begin
    ut     = under_target(sum_unu, sum_tot);
    diff_w = {2'b00, sum_tot} - {sum_unu, 2'b00};
    diff   = diff_w[HW-1:0];
    for (int k = 0; k <= BUF_W; k++) begin
      ge[k] = ut && (diff >= (HW'(3) << k));
    end
    for (int k = 0; k < BUF_W; k++) begin
      p2[k] = ge[k] && !ge[k+1];
    end
    shr_sz   = (p2 > minsz) ? p2 : minsz;
    base_buf = (s1_cmd_r == CMD_START) ? capped : buf_now_r;
    // a target of 2^25 or more never shrinks anything
    shrink   = adj_en_r && !ge[BUF_W] && (shr_sz < base_buf)
               && !((s1_cmd_r == CMD_DISCARD) && ut);
  end

  // next state
  logic               inc;
  logic [DEPTH_W-1:0] depth_inc, start_depth;

  always_comb begin
    inc         = s1_waited_r && (depth_r < ra_limit_r) && !growing_r;
    depth_inc   = depth_r + DEPTH_W'(1);
    start_depth = adj_en_r ? ((hist_r < ra_limit_r) ? hist_r : ra_limit_r)
                           : DEPTH_W'(ra_limit_r != '0);

    cur_tot_nxt = w_cur_tot;
    cur_unu_nxt = w_cur_unu;
    prv_tot_nxt = w_prv_tot;
    prv_unu_nxt = w_prv_unu;
    buf_now_nxt = buf_now_r;
    depth_nxt   = depth_r;
    hist_nxt    = hist_r;
    growing_nxt = growing_r;

    unique case (s1_cmd_r)
      CMD_CONSUME: begin
        if (inc) begin
          depth_nxt = depth_inc;
          if (adj_en_r && (depth_inc > hist_r)) hist_nxt = depth_inc;
        end
        if (adj_en_r && growing_r && grow_ok) begin
          buf_now_nxt = grow_sz[BUF_W-1:0];
          growing_nxt = grow_sz < {1'b0, capped};
        end
      end
      CMD_DISCARD: begin
        if (shrink) begin
          growing_nxt = 1'b1;
          depth_nxt   = (depth_r > DEPTH_W'(1)) ? DEPTH_W'(1) : depth_r;
          buf_now_nxt = shr_sz;
        end
      end
      CMD_START: begin
        growing_nxt = shrink;
        if (shrink) begin
          depth_nxt   = (start_depth > DEPTH_W'(1)) ? DEPTH_W'(1) : start_depth;
          buf_now_nxt = shr_sz;
        end else begin
          depth_nxt   = start_depth;
          buf_now_nxt = capped;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_tot_r <= '0;
      cur_unu_r <= '0;
      prv_tot_r <= '0;
      prv_unu_r <= '0;
      buf_now_r <= '0;
      depth_r   <= '0;
      hist_r    <= '0;
      growing_r <= 1'b0;
    end else if (s1_adv) begin
      cur_tot_r <= cur_tot_nxt;
      cur_unu_r <= cur_unu_nxt;
      prv_tot_r <= prv_tot_nxt;
      prv_unu_r <= prv_unu_nxt;
      buf_now_r <= buf_now_nxt;
      depth_r   <= depth_nxt;
      hist_r    <= hist_nxt;
      growing_r <= growing_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r.cur_buffer_bytes   <= buf_now_nxt;
      out_res_r.cur_read_ahead     <= depth_nxt;
      out_res_r.slow_start         <= growing_nxt;
      out_res_r.learned_read_ahead <= hist_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-$bits(arsz_result_t)){1'b0}}, out_res_r};

  `ARSZ_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_r, "request lost between stages")
  `ARSZ_ASSERT_NOW(a_stall_cause, !in_tready, s1_valid_r && out_valid_r && !out_tready, "input stalled without backpressure")
  `ARSZ_ASSERT_NOW(a_slow_depth, growing_r, depth_r <= DEPTH_W'(1), "read-ahead above one in slow start")

endmodule
